// ===== src/fpcvt_pkg.sv =====
// Package for the binary32 / binary16 converter.
// Holds field widths, exponent constants and the leading-zero count.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fpcvt_pkg;

  localparam int unsigned SingleW  = 32;
  localparam int unsigned HalfW    = 16;
  localparam int unsigned SExpW    = 8;
  localparam int unsigned SManW    = 23;
  localparam int unsigned HExpW    = 5;
  localparam int unsigned HManW    = 10;
  localparam int unsigned CmdW     = 1;
  localparam int unsigned InDataW  = SingleW + HalfW;
  localparam int unsigned OutDataW = HalfW + SingleW;
  localparam int unsigned LzW      = 4;

  localparam logic [CmdW-1:0] CmdToHalf   = 1'b0;
  localparam logic [CmdW-1:0] CmdToSingle = 1'b1;

  localparam logic [SExpW-1:0] BiasDiff    = 8'd112;
  localparam logic [SExpW-1:0] SubShiftRef = 8'd113;
  localparam logic [SExpW-1:0] TinyLimit   = 8'd102;
  localparam logic [SExpW-1:0] SExpMax     = 8'hff;
  localparam logic [SExpW-1:0] HExpTop     = 8'd30;
  localparam logic [HExpW-1:0] HExpMax     = 5'h1f;

  function automatic logic [LzW-1:0] lzc10(input logic [HManW-1:0] man);
    logic [LzW-1:0] cnt;
    logic           found;
    cnt   = LzW'(HManW);
    found = 1'b0;
    for (int i = HManW - 1; i >= 0; i--) begin
      if (!found && man[i]) begin
        cnt   = LzW'(HManW - 1 - i);
        found = 1'b1;
      end
    end
    return cnt;
  endfunction

endpackage

`default_nettype wire

// ===== src/fpcvt_to_half.sv =====
// Binary32 to binary16 conversion, combinational.
// Round to nearest with ties away from zero; uses fpcvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpcvt_to_half (
  input  wire logic [fpcvt_pkg::SingleW-1:0] single_i,
  output logic      [fpcvt_pkg::HalfW-1:0]   half_o
);

  logic                          sign;
  logic [fpcvt_pkg::SExpW-1:0]   exp8;
  logic [fpcvt_pkg::SManW-1:0]   man;
  logic [fpcvt_pkg::LzW-1:0]     sub_shift;
  logic [fpcvt_pkg::SManW:0]     sub_man;
  logic [fpcvt_pkg::SManW:0]     sub_rnd;
  logic [fpcvt_pkg::SManW:0]     nrm_sum;
  logic                          carry;
  logic [fpcvt_pkg::SExpW-1:0]   nrm_exp;
  logic [fpcvt_pkg::HManW-1:0]   nan_man;
  logic [fpcvt_pkg::SExpW-1:0]   shift_full;

  always_comb begin
    sign       = single_i[31];
    exp8       = single_i[30:23];
    man        = single_i[22:0];
    shift_full = fpcvt_pkg::SubShiftRef - exp8;
    sub_shift  = shift_full[fpcvt_pkg::LzW-1:0];
    sub_man    = {1'b1, man} >> sub_shift;
    sub_rnd    = sub_man + (sub_man[12] ? 24'h002000 : 24'h000000);
    nrm_sum    = {1'b0, man} + (man[12] ? 24'h002000 : 24'h000000);
    carry      = nrm_sum[23];
    nrm_exp    = exp8 - fpcvt_pkg::BiasDiff + {7'd0, carry};
    nan_man    = man[22:13] | {9'd0, (man[22:13] == 10'd0)};

    priority if (exp8 < fpcvt_pkg::TinyLimit) begin
      half_o = {sign, 15'd0};
    end else if (exp8 <= fpcvt_pkg::BiasDiff) begin
      half_o = {sign, 4'd0, sub_rnd[23:13]};
    end else if (exp8 == fpcvt_pkg::SExpMax) begin
      if (man == 23'd0) begin
        half_o = {sign, fpcvt_pkg::HExpMax, 10'd0};
      end else begin
        half_o = {sign, fpcvt_pkg::HExpMax, nan_man};
      end
    end else if (nrm_exp > fpcvt_pkg::HExpTop) begin
      half_o = {sign, fpcvt_pkg::HExpMax, 10'd0};
    end else begin
      half_o = {sign, nrm_exp[4:0], nrm_sum[22:13]};
    end
  end

endmodule

`default_nettype wire

// ===== src/fpcvt_to_single.sv =====
// Binary16 to binary32 conversion, combinational.
// Renormalizes denormals with a leading-zero count; uses fpcvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpcvt_to_single (
  input  wire logic [fpcvt_pkg::HalfW-1:0]   half_i,
  output logic      [fpcvt_pkg::SingleW-1:0] single_o
);

  logic                        sign;
  logic [fpcvt_pkg::HExpW-1:0] exp5;
  logic [fpcvt_pkg::HManW-1:0] man;
  logic [fpcvt_pkg::LzW-1:0]   lz;
  logic [fpcvt_pkg::HManW:0]   norm_man;
  logic [fpcvt_pkg::SExpW-1:0] den_exp;
  logic [fpcvt_pkg::SExpW-1:0] nrm_exp;

  always_comb begin
    sign     = half_i[15];
    exp5     = half_i[14:10];
    man      = half_i[9:0];
    lz       = fpcvt_pkg::lzc10(man);
    norm_man = {1'b0, man} << (lz + 4'd1);
    den_exp  = fpcvt_pkg::BiasDiff - {4'd0, lz};
    nrm_exp  = {3'd0, exp5} + fpcvt_pkg::BiasDiff;

    if (exp5 == 5'd0) begin
      if (man == 10'd0) begin
        single_o = {sign, 31'd0};
      end else begin
        single_o = {sign, den_exp, norm_man[9:0], 13'd0};
      end
    end else if (exp5 == fpcvt_pkg::HExpMax) begin
      single_o = {sign, fpcvt_pkg::SExpMax, man, 13'd0};
    end else begin
      single_o = {sign, nrm_exp, man, 13'd0};
    end
  end

endmodule

`default_nettype wire

// ===== src/fp32_fp16_convert_core.sv =====
// Top level of the binary32 / binary16 converter: input register, conversion
// logic, result register. Uses fpcvt_pkg, fpcvt_to_half, fpcvt_to_single.
//
//   channel  dir  tdata (low bit up)                      tuser
//   s_axis   in   single_bits[31:0], half_bits[47:32]      cmd[0]
//   m_axis   out  half_result[15:0], single_result[47:16]  -
//
// One item per cycle while m_axis does not stall; an accepted item passes
// through the input register and then the result register to m_axis.
// Reset clears both valid flags; data registers are not reset.
// A stall on m_axis holds the result and lets the input register fill,
// then drops s_axis_tready until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module fp32_fp16_convert_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [fpcvt_pkg::InDataW-1:0]      s_axis_tdata,  // single_bits, half_bits
  input  wire logic [fpcvt_pkg::CmdW-1:0]         s_axis_tuser,  // cmd
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic      [fpcvt_pkg::OutDataW-1:0]     m_axis_tdata   // half_result, single_result
);

  logic                              in_valid_q;
  logic [fpcvt_pkg::CmdW-1:0]        cmd_q;
  logic [fpcvt_pkg::SingleW-1:0]     single_q;
  logic [fpcvt_pkg::HalfW-1:0]       half_q;
  logic                              out_valid_q;
  logic [fpcvt_pkg::OutDataW-1:0]    out_data_q;
  logic [fpcvt_pkg::OutDataW-1:0]    out_data_d;
  logic [fpcvt_pkg::HalfW-1:0]       half_res;
  logic [fpcvt_pkg::SingleW-1:0]     single_res;
  logic                              out_load;
  logic                              in_load;

  fpcvt_to_half u_to_half (
    .single_i (single_q),
    .half_o   (half_res)
  );

  fpcvt_to_single u_to_single (
    .half_i   (half_q),
    .single_o (single_res)
  );

  always_comb begin
    out_load      = !out_valid_q || m_axis_tready;
    in_load       = !in_valid_q || out_load;
    s_axis_tready = in_load;
    m_axis_tvalid = out_valid_q;
    m_axis_tdata  = out_data_q;
    if (cmd_q == fpcvt_pkg::CmdToSingle) begin
      out_data_d = {single_res, 16'd0};
    end else begin
      out_data_d = {32'd0, half_res};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_load) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_load) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && s_axis_tvalid) begin
      cmd_q    <= s_axis_tuser;
      single_q <= s_axis_tdata[31:0];
      half_q   <= s_axis_tdata[47:32];
    end
    if (out_load && in_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

`default_nettype wire
